// ===== rtl/core/bia_pkg.sv =====
`default_nettype none
package bia_pkg;

  // command codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int WORD_BITS = 64;
  localparam logic [WORD_BITS-1:0] RESERVED_WORD = 64'h3ff;
  localparam logic [WORD_BITS-1:0] FULL_WORD     = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] mark_index;
  } req_item_t;

  typedef struct packed {
    logic [11:0] result_index;
    logic [1:0]  status;
  } rsp_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       sweep_init;
    logic       sweep_write;
    logic       mark_write;
    logic       scan_init;
    logic       scan_step;
    logic       alloc_write;
    logic       res_load;
    logic       res_alloc;
    logic [1:0] res_status;
    logic       out_load;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic mark_oor;
    logic word_full;
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bia_ram.sv =====
`default_nettype none
module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bia_dp.sv =====
`default_nettype none
module bia_dp
  import bia_pkg::*;
#(
  parameter int NUM_INDEXES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_ctl_t     ctl,
  input  wire logic [15:0] mark_index,
  output dp_stat_t         stat,
  output rsp_item_t        rsp
);

  localparam int MAP_WORDS = NUM_INDEXES / WORD_BITS;
  localparam int AW = $clog2(MAP_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  logic [15:0]          op_idx;
  logic [AW-1:0]        addr_cnt;
  logic [AW-1:0]        chk_addr;
  logic [11:0]          pend_index;
  logic [1:0]           pend_status;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [AW-1:0]        mark_word;
  logic [WORD_BITS-1:0] word_inc;
  logic [WORD_BITS-1:0] free_onehot;
  logic [5:0]           free_bit;
  logic [15:0]          alloc_index;

  bia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign mark_word = op_idx[AW+5:6];

  // lowest zero bit: w + 1 carries through the trailing ones
  assign word_inc    = mem_rdata + WORD_BITS'(1);
  assign free_onehot = ~mem_rdata & word_inc;

  // one-hot to binary
  always_comb begin
    free_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_onehot[i]) begin
        free_bit = free_bit | 6'(i);
      end
    end
  end

  assign alloc_index = 16'({chk_addr, free_bit});

  // read address select
  always_comb begin
    if (ctl.scan_init) begin
      mem_raddr = '0;
    end else if (ctl.scan_step) begin
      mem_raddr = addr_cnt;
    end else begin
      mem_raddr = mark_word;
    end
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_cnt;
    mem_wdata = '0;
    if (ctl.sweep_write) begin
      mem_we    = 1'b1;
      mem_waddr = addr_cnt;
      mem_wdata = (addr_cnt == '0) ? RESERVED_WORD : '0;
    end else if (ctl.mark_write) begin
      mem_we    = 1'b1;
      mem_waddr = mark_word;
      mem_wdata = mem_rdata | (WORD_BITS'(1) << op_idx[5:0]);
    end else if (ctl.alloc_write) begin
      mem_we    = 1'b1;
      mem_waddr = chk_addr;
      mem_wdata = mem_rdata | word_inc;
    end
  end

  // status back to the controller
  assign stat.sweep_last = (addr_cnt == LAST_WORD);
  assign stat.mark_oor   = ({22'b0, op_idx[15:6]} >= 32'(MAP_WORDS));
  assign stat.word_full  = (mem_rdata == FULL_WORD);
  assign stat.scan_last  = (chk_addr == LAST_WORD);

  // word counters
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_cnt <= '0;
      chk_addr <= '0;
    end else begin
      if (ctl.sweep_init) begin
        addr_cnt <= '0;
      end else if (ctl.sweep_write) begin
        addr_cnt <= addr_cnt + AW'(1);
      end else if (ctl.scan_init) begin
        addr_cnt <= AW'(1);
        chk_addr <= '0;
      end else if (ctl.scan_step) begin
        addr_cnt <= addr_cnt + AW'(1);
        chk_addr <= addr_cnt;
      end
    end
  end

  // captured index, pending and output result
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_idx <= mark_index;
    end
    if (ctl.res_load) begin
      pend_index  <= ctl.res_alloc ? alloc_index[11:0] : '0;
      pend_status <= ctl.res_status;
    end
    if (ctl.out_load) begin
      rsp.result_index <= pend_index;
      rsp.status       <= pend_status;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bia_ctrl.sv =====
`default_nettype none
module bia_ctrl
  import bia_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] opcode,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  input  wire dp_stat_t   stat,
  output dp_ctl_t         ctl
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_SCAN_START,
    S_SCAN,
    S_RESP
  } state_t;

  state_t state;
  logic   sweep_item;
  logic   accept;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // datapath commands
  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.capture    = 1'b1;
          ctl.sweep_init = 1'b1;
          if (opcode != OP_CLEAR && opcode != OP_MARK && opcode != OP_ALLOC) begin
            ctl.res_load   = 1'b1;
            ctl.res_status = STATUS_OK;
          end
        end
      end
      S_SWEEP: begin
        ctl.sweep_write = 1'b1;
        if (stat.sweep_last && sweep_item) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = STATUS_OK;
        end
      end
      S_MARK_RD: begin
        if (stat.mark_oor) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = STATUS_RANGE;
        end
      end
      S_MARK_WR: begin
        ctl.mark_write = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_status = STATUS_OK;
      end
      S_SCAN_START: begin
        ctl.scan_init = 1'b1;
      end
      S_SCAN: begin
        if (!stat.word_full) begin
          ctl.alloc_write = 1'b1;
          ctl.res_load    = 1'b1;
          ctl.res_alloc   = 1'b1;
          ctl.res_status  = STATUS_OK;
        end else if (stat.scan_last) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = STATUS_FULL;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_RESP: begin
        ctl.out_load = out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_item <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (opcode)
              OP_CLEAR: begin
                state      <= S_SWEEP;
                sweep_item <= 1'b1;
              end
              OP_MARK:  state <= S_MARK_RD;
              OP_ALLOC: state <= S_SCAN_START;
              default:  state <= S_RESP;
            endcase
          end
        end
        S_SWEEP: begin
          if (stat.sweep_last) begin
            state      <= sweep_item ? S_RESP : S_IDLE;
            sweep_item <= 1'b0;
          end
        end
        S_MARK_RD: begin
          state <= stat.mark_oor ? S_RESP : S_MARK_WR;
        end
        S_MARK_WR: begin
          state <= S_RESP;
        end
        S_SCAN_START: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!stat.word_full || stat.scan_last) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_index_allocator_unit.sv =====
`default_nettype none
// First-fit allocator over a bitmap of NUM_INDEXES indexes, held in a RAM of
// W = NUM_INDEXES/64 words of 64 bits (bit b of word w is index w*64+b).
// Request channel (req_valid, req_stall, req): opcode clear, mark or allocate,
// plus the index to mark. Response channel (rsp_valid, rsp_stall, rsp): one
// transaction per request with result_index and status.
// One request is worked on at a time; req_stall is high while it runs.
// Work from accept to rsp_valid:
//   clear     one RAM write per word
//   mark      read, modify, write; no write when out of range
//   allocate  words from 0 up to the first with a free bit, or all when full
//             (one word read and tested per cycle through the RAM read port)
//   other     response with status OK
// A further request can be accepted in the cycle after the response is loaded.
// After reset the map is swept the same way as a clear, with no response
// and with req_stall high; it then holds indexes 0 to 9 reserved.
// The response sits in an output register; while rsp_stall holds it, the
// next request may still be accepted and run, and its result waits inside
// until the output register is taken.
module bitmap_index_allocator_unit
  import bia_pkg::*;
#(
  parameter int NUM_INDEXES = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode   (req.opcode),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  bia_dp #(
    .NUM_INDEXES(NUM_INDEXES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .mark_index(req.mark_index),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
